>>> hw/rtl/periodic_task_tick_scheduler_defines.svh
// Assertion macros used by the scheduler engine RTL.
// Each use expects clock and reset signals in the enclosing module.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define PTS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PTS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define PTS_ASSERT(lbl, prop, msg)
`define PTS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> hw/rtl/pts_pkg.sv
package pts_pkg;

   localparam int NUM_TASKS_DEF = 8;
   localparam int MAX_RESULTS   = 8;
   localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
   localparam int TIME_W        = 16;
   localparam int REQ_W         = 4;
   localparam int SLOT_W        = 3;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_CREATE  = 2'd1,
      OP_SUSPEND = 2'd2,
      OP_RESUME  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACK,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [REQ_W-1:0]    task_req;
      logic [TIME_W-1:0]   period;
      logic [TIME_W-1:0]   first_delay;
   } req_type;

   typedef struct packed {
      logic                fired;
      logic [SLOT_W-1:0]   fired_task;
      logic                last;
   } rsp_type;

   // One slot entry as stored in the slot memory.
   typedef struct packed {
      logic [TIME_W-1:0]   period;
      logic [TIME_W-1:0]   countdown;
   } entry_type;

endpackage

>>> hw/rtl/pts_table.sv
module pts_table #(
   parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output pts_pkg::entry_type   rd_data,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  pts_pkg::entry_type   wr_data
);
   import pts_pkg::*;

   entry_type              slot_mem_ff [NUM_TASKS];
   entry_type              rd_q_ff;
   logic                   rd_init_ff;
   logic [NUM_TASKS-1:0]   init_ff;

   // Write one entry; read one entry with a registered result
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= slot_mem_ff[rd_addr];
      end
   end

   // Track which entries hold written data; unwritten ones read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff    <= '0;
         rd_init_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            init_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_init_ff <= init_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_init_ff ? rd_q_ff : '0;

endmodule

>>> hw/rtl/pts_engine.sv
`include "periodic_task_tick_scheduler_defines.svh"

module pts_engine #(
   parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pts_pkg::req_type     req_data,
   input  logic                 out_free,
   output logic                 rsp_load,
   output pts_pkg::rsp_type     rsp_in,
   output logic                 mem_rd_en,
   output logic [IDX_W-1:0]     mem_rd_addr,
   input  pts_pkg::entry_type   mem_rd_data,
   output logic                 mem_wr_en,
   output logic [IDX_W-1:0]     mem_wr_addr,
   output pts_pkg::entry_type   mem_wr_data
);
   import pts_pkg::*;

   state_type              state_ff, state_in;
   logic [IDX_W:0]         rd_cnt_ff, rd_cnt_in;
   logic                   ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]       ev_idx_ff, ev_idx_in;
   logic                   hold_valid_ff, hold_valid_in;
   logic [SLOT_W-1:0]      hold_task_ff, hold_task_in;
   logic [CNT_W-1:0]       rep_cnt_ff, rep_cnt_in;
   logic [NUM_TASKS-1:0]   ready_ff, ready_in;
   logic [NUM_TASKS-1:0]   created_ff, created_in;

   logic                   accept;
   logic                   in_range;
   logic [IDX_W-1:0]       req_idx;
   logic                   ev_ready;
   logic                   ev_fire;
   logic                   ev_report;
   logic                   push_prev;
   logic                   stall;
   logic                   rd_more;
   logic [TIME_W-1:0]      reload_base;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_range  = {1'b0, req_data.task_req} < (REQ_W + 1)'(NUM_TASKS);
   assign req_idx   = req_data.task_req[IDX_W-1:0];

   // Evaluate the slot whose entry just came out of the memory
   assign ev_ready  = ready_ff[ev_idx_ff];
   assign ev_fire   = ev_valid_ff && ev_ready && (mem_rd_data.countdown == '0);
   assign ev_report = ev_fire && created_ff[ev_idx_ff] &&
                      (rep_cnt_ff < CNT_W'(MAX_RESULTS));
   assign push_prev = ev_report && hold_valid_ff;
   assign stall     = push_prev && !out_free;
   assign rd_more   = rd_cnt_ff < (IDX_W + 1)'(NUM_TASKS);

   // Fire reloads to period - 1, otherwise count down by one
   assign reload_base = (mem_rd_data.countdown == '0) ? mem_rd_data.period
                                                      : mem_rd_data.countdown;

   // Next state, memory access and result generation
   always_comb begin
      state_in      = state_ff;
      rd_cnt_in     = rd_cnt_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      hold_valid_in = hold_valid_ff;
      hold_task_in  = hold_task_ff;
      rep_cnt_in    = rep_cnt_ff;
      ready_in      = ready_ff;
      created_in    = created_ff;
      rsp_load      = 1'b0;
      rsp_in        = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rd_cnt_ff[IDX_W-1:0];
      mem_wr_en     = 1'b0;
      mem_wr_addr   = ev_idx_ff;
      mem_wr_data.period    = mem_rd_data.period;
      mem_wr_data.countdown = reload_base - TIME_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.op)
                  OP_TICK: begin
                     state_in      = ST_SWEEP;
                     rd_cnt_in     = '0;
                     ev_valid_in   = 1'b0;
                     rep_cnt_in    = '0;
                     hold_valid_in = 1'b0;
                  end
                  OP_CREATE: begin
                     state_in = ST_ACK;
                     if (in_range) begin
                        mem_wr_en             = 1'b1;
                        mem_wr_addr           = req_idx;
                        mem_wr_data.period    = req_data.period;
                        mem_wr_data.countdown = req_data.first_delay;
                        ready_in[req_idx]     = 1'b1;
                        created_in[req_idx]   = 1'b1;
                     end
                  end
                  OP_SUSPEND: begin
                     state_in = ST_ACK;
                     if (in_range) begin
                        ready_in[req_idx] = 1'b0;
                     end
                  end
                  OP_RESUME: begin
                     state_in = ST_ACK;
                     if (in_range) begin
                        ready_in[req_idx] = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_ACK;
                  end
               endcase
            end
         end
         ST_ACK: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_in.last = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (!stall) begin
               // Write back the evaluated slot
               if (ev_valid_ff && ev_ready) begin
                  mem_wr_en = 1'b1;
               end
               // Hold the newest report so the final one can carry last
               if (ev_report) begin
                  if (hold_valid_ff) begin
                     rsp_load          = 1'b1;
                     rsp_in.fired      = 1'b1;
                     rsp_in.fired_task = hold_task_ff;
                  end
                  hold_valid_in = 1'b1;
                  hold_task_in  = SLOT_W'(ev_idx_ff);
                  rep_cnt_in    = rep_cnt_ff + CNT_W'(1);
               end
               // Advance the read pointer
               if (rd_more) begin
                  mem_rd_en   = 1'b1;
                  ev_valid_in = 1'b1;
                  ev_idx_in   = rd_cnt_ff[IDX_W-1:0];
                  rd_cnt_in   = rd_cnt_ff + (IDX_W + 1)'(1);
               end else begin
                  ev_valid_in = 1'b0;
                  if (!ev_valid_ff) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_load          = 1'b1;
               rsp_in.fired      = hold_valid_ff;
               rsp_in.fired_task = hold_valid_ff ? hold_task_ff : '0;
               rsp_in.last       = 1'b1;
               hold_valid_in     = 1'b0;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sweep control and slot flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff     <= '0;
         ev_valid_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
         rep_cnt_ff    <= '0;
         ready_ff      <= '0;
         created_ff    <= '0;
      end else begin
         rd_cnt_ff     <= rd_cnt_in;
         ev_valid_ff   <= ev_valid_in;
         hold_valid_ff <= hold_valid_in;
         rep_cnt_ff    <= rep_cnt_in;
         ready_ff      <= ready_in;
         created_ff    <= created_in;
      end
   end

   // Slot index and held report carry no reset
   always_ff @(posedge clock) begin
      ev_idx_ff    <= ev_idx_in;
      hold_task_ff <= hold_task_in;
   end

   `PTS_ASSERT(a_idle_clean, (state_ff == ST_IDLE) |-> (!hold_valid_ff && !ev_valid_ff), "idle with sweep state left over")
   `PTS_ASSERT(a_rep_bound, rep_cnt_ff <= CNT_W'(MAX_RESULTS), "report count beyond limit")
   `PTS_ASSERT(a_no_rw_clash, (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr), "read and write of one slot in one cycle")
   `PTS_ASSERT(a_sweep_not_last, ((state_ff == ST_SWEEP) && rsp_load) |-> (!rsp_in.last && rsp_in.fired), "sweep pushed a final result")

endmodule

>>> hw/rtl/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler: NUM_TASKS slots, index 0 the highest priority, each with a
// 16-bit period and countdown kept in a single-port-read, single-port-write slot memory with
// a registered read. Create, suspend and resume pass through an acknowledge state and return
// one acknowledge. A tick sweeps the slots: it reads one slot per cycle while not stalled and
// writes back the previous one; results wait in one output register, and a stalled result
// consumer holds the sweep. A tick returns one result per fired created slot in priority
// order (up to eight), or one none-fired result, with last set on the final one. No item is
// taken while a tick or acknowledge is in progress.
module periodic_task_tick_scheduler #(
   parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pts_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pts_pkg::rsp_type  rsp_data
);
   import pts_pkg::*;

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   logic               out_free;
   logic               rsp_load;
   rsp_type            rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;
   logic               mem_rd_en;
   logic [IDX_W-1:0]   mem_rd_addr;
   entry_type          mem_rd_data;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   entry_type          mem_wr_data;

   pts_engine #(
      .NUM_TASKS (NUM_TASKS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .rsp_in      (rsp_in),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   pts_table #(
      .NUM_TASKS (NUM_TASKS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // Output register: free when empty or draining this cycle
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pts_pkg::*;

   localparam int SLOTS       = NUM_TASKS_DEF;
   localparam int CYCLE_LIMIT = 400_000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Scheduler state as the testbench sees it
   logic [TIME_W-1:0] slot_period    [SLOTS];
   logic [TIME_W-1:0] slot_countdown [SLOTS];
   logic              slot_ready     [SLOTS];
   logic              slot_created   [SLOTS];

   rsp_type pending_rsp[$];
   rsp_type oldest_rsp;
   int      n_errors      = 0;
   int      cycle_count   = 0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;

   periodic_task_tick_scheduler #(
      .NUM_TASKS(SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout at %0t with %0d results outstanding", $time, pending_rsp.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Apply one transaction to the scheduler state and queue the results it causes
   task automatic schedule_step(input req_type item);
      int      fired_slots[$];
      rsp_type r;
      int      i;
      if (item.op != OP_TICK) begin
         if (item.task_req < SLOTS) begin
            case (item.op)
               OP_CREATE: begin
                  slot_period[item.task_req]    = item.period;
                  slot_countdown[item.task_req] = item.first_delay;
                  slot_ready[item.task_req]     = 1'b1;
                  slot_created[item.task_req]   = 1'b1;
               end
               OP_SUSPEND: slot_ready[item.task_req] = 1'b0;
               default:    slot_ready[item.task_req] = 1'b1;
            endcase
         end
      end else begin
         // Sweep slots in priority order; uncreated slots still reload but stay silent
         for (i = 0; i < SLOTS; i++) begin
            if (slot_ready[i]) begin
               if (slot_countdown[i] == '0) begin
                  if (slot_created[i] && fired_slots.size() < MAX_RESULTS)
                     fired_slots.push_back(i);
                  slot_countdown[i] = slot_period[i] - 16'd1;
               end else begin
                  slot_countdown[i] = slot_countdown[i] - 16'd1;
               end
            end
         end
      end
      if (fired_slots.size() == 0) begin
         r.fired      = 1'b0;
         r.fired_task = '0;
         r.last       = 1'b1;
         pending_rsp.push_back(r);
      end else begin
         foreach (fired_slots[k]) begin
            r.fired      = 1'b1;
            r.fired_task = SLOT_W'(fired_slots[k]);
            r.last       = (k == fired_slots.size() - 1);
            pending_rsp.push_back(r);
         end
      end
   endtask

   // Drive one transaction, with a random idle gap in front of it
   task automatic send_req(input req_type item);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      schedule_step(item);
   endtask

   // Hold the input side until every expected result is back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   function automatic req_type make_req(input op_type op, input int slot,
                                        input int per, input int dly);
      req_type item;
      item.op          = op;
      item.task_req    = REQ_W'(slot);
      item.period      = TIME_W'(per);
      item.first_delay = TIME_W'(dly);
      return item;
   endfunction

   function automatic req_type random_req();
      req_type item;
      int      pick;
      pick             = $urandom_range(99, 0);
      item.period      = TIME_W'($urandom);
      item.first_delay = TIME_W'($urandom);
      if ($urandom_range(99, 0) < 80)
         item.task_req = REQ_W'($urandom_range(SLOTS - 1, 0));
      else
         item.task_req = REQ_W'($urandom_range(15, 0));
      if (pick < 45) begin
         item.op = OP_TICK;
      end else if (pick < 75) begin
         // Mostly short periods and delays so slots keep firing
         item.op = OP_CREATE;
         pick    = $urandom_range(99, 0);
         if (pick < 70) begin
            item.period = TIME_W'($urandom_range(6, 0));
         end else if (pick < 85) begin
            case ($urandom_range(2, 0))
               0:       item.period = '0;
               1:       item.period = TIME_W'(1);
               default: item.period = '1;
            endcase
         end
         if ($urandom_range(99, 0) < 75)
            item.first_delay = TIME_W'($urandom_range(8, 0));
      end else if (pick < 87) begin
         item.op = OP_SUSPEND;
      end else begin
         item.op = OP_RESUME;
      end
      return item;
   endfunction

   // Stall the result side at random and check each result against the oldest expectation
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result fired=%0b fired_task=%0d last=%0b",
                     $time, rsp_data.fired, rsp_data.fired_task, rsp_data.last);
            n_errors++;
         end else begin
            oldest_rsp = pending_rsp.pop_front();
            if (rsp_data.fired !== oldest_rsp.fired) begin
               $display("%0t: fired expected %0b actual %0b",
                        $time, oldest_rsp.fired, rsp_data.fired);
               n_errors++;
            end
            if (rsp_data.fired_task !== oldest_rsp.fired_task) begin
               $display("%0t: fired_task expected %0d actual %0d",
                        $time, oldest_rsp.fired_task, rsp_data.fired_task);
               n_errors++;
            end
            if (rsp_data.last !== oldest_rsp.last) begin
               $display("%0t: last expected %0b actual %0b",
                        $time, oldest_rsp.last, rsp_data.last);
               n_errors++;
            end
         end
      end
   end

   task automatic test_idle_tick();
      send_req(make_req(OP_TICK, 0, 0, 0));
   endtask

   // Slot runs its countdown without ever being reported
   task automatic test_uncreated_resume();
      send_req(make_req(OP_RESUME, 5, 0, 0));
      send_req(make_req(OP_TICK, 0, 0, 0));
      send_req(make_req(OP_SUSPEND, 5, 0, 0));
   endtask

   // Period one reloads to zero, period zero wraps to the top of the range
   task automatic test_period_extremes();
      send_req(make_req(OP_CREATE, 0, 1, 0));
      send_req(make_req(OP_TICK, 0, 0, 0));
      send_req(make_req(OP_CREATE, SLOTS - 1, 0, 0));
      send_req(make_req(OP_TICK, 0, 0, 0));
      send_req(make_req(OP_CREATE, 3, 16'hFFFF, 16'hFFFF));
   endtask

   task automatic test_suspend_resume();
      send_req(make_req(OP_SUSPEND, 0, 0, 0));
      send_req(make_req(OP_TICK, 0, 0, 0));
      send_req(make_req(OP_RESUME, 0, 0, 0));
   endtask

   // Indexes past the table are acknowledged and change nothing
   task automatic test_out_of_range();
      send_req(make_req(OP_CREATE, SLOTS, 16'hFFFF, 16'hFFFF));
      send_req(make_req(OP_SUSPEND, 15, 16'hFFFF, 16'hFFFF));
      send_req(make_req(OP_RESUME, 9, 0, 0));
      send_req(make_req(OP_TICK, 0, 0, 0));
   endtask

   // Every slot fires on the same tick
   task automatic test_all_slots_fire();
      int s;
      for (s = 0; s < SLOTS; s++)
         send_req(make_req(OP_CREATE, s, 1, 0));
      send_req(make_req(OP_TICK, 0, 0, 0));
   endtask

   task automatic test_random(input int count, input int idle_pct, input int stall_pct);
      int n;
      hold_until_drained();
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(99, 0) < 3)
            hold_until_drained();
         send_req(random_req());
      end
   endtask

   initial begin
      slot_period    = '{default: '0};
      slot_countdown = '{default: '0};
      slot_ready     = '{default: 1'b0};
      slot_created   = '{default: 1'b0};
      send_idle_pct  = 15;
      rsp_stall_pct  = 87;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_idle_tick();
      test_uncreated_resume();
      test_period_extremes();
      test_suspend_resume();
      test_out_of_range();
      test_all_slots_fire();
      test_random(100, 15, 87);
      test_random(100, 87, 15);
      test_random(100, 0, 0);

      // Let the last results drain, then keep watching for stray output
      hold_until_drained();
      repeat (SLOTS + 8) @(posedge clock);
      if (n_errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
